// ===== hdl/rmd_pkg.sv =====
// Package: types, constants and round tables for the RIPEMD-160 hash unit.
package rmd_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_item;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam int unsigned ROUNDS = 80;

    function automatic logic [31:0] k_left(input logic [2:0] g);
        unique case (g)
            3'd0:    k_left = 32'h00000000;
            3'd1:    k_left = 32'h5a827999;
            3'd2:    k_left = 32'h6ed9eba1;
            3'd3:    k_left = 32'h8f1bbcdc;
            default: k_left = 32'ha953fd4e;
        endcase
    endfunction

    function automatic logic [31:0] k_right(input logic [2:0] g);
        unique case (g)
            3'd0:    k_right = 32'h50a28be6;
            3'd1:    k_right = 32'h5c4dd124;
            3'd2:    k_right = 32'h6d703ef3;
            3'd3:    k_right = 32'h7a6d76e9;
            default: k_right = 32'h00000000;
        endcase
    endfunction

    function automatic logic [31:0] bool_fn(input logic [2:0] g, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
        unique case (g)
            3'd0:    bool_fn = x ^ y ^ z;
            3'd1:    bool_fn = (x & y) | (~x & z);
            3'd2:    bool_fn = (x | ~y) ^ z;
            3'd3:    bool_fn = (x & z) | (y & ~z);
            default: bool_fn = x ^ (y | ~z);
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        rotl = d[63:32];
    endfunction

    localparam logic [3:0] SEL_L [ROUNDS] = '{
        4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
        4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
        4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
        4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
        4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13
    };
    localparam logic [3:0] SEL_R [ROUNDS] = '{
        4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
        4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
        4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
        4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
        4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11
    };
    localparam logic [4:0] ROT_L [ROUNDS] = '{
        5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,5'd7,5'd9,5'd8,
        5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,5'd9,5'd11,5'd7,5'd13,5'd12,
        5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,5'd14,5'd8,5'd13,5'd6,5'd5,5'd12,5'd7,5'd5,
        5'd11,5'd12,5'd14,5'd15,5'd14,5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,5'd5,5'd12,
        5'd9,5'd15,5'd5,5'd11,5'd6,5'd8,5'd13,5'd12,5'd5,5'd12,5'd13,5'd14,5'd11,5'd8,5'd5,5'd6
    };
    localparam logic [4:0] ROT_R [ROUNDS] = '{
        5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,5'd14,5'd12,5'd6,
        5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,5'd12,5'd7,5'd6,5'd15,5'd13,5'd11,
        5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,5'd13,5'd7,5'd5,
        5'd15,5'd5,5'd8,5'd11,5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,5'd15,5'd8,
        5'd8,5'd5,5'd12,5'd9,5'd12,5'd5,5'd14,5'd6,5'd8,5'd13,5'd6,5'd5,5'd15,5'd13,5'd11,5'd11
    };

endpackage

// ===== hdl/rmd_front.sv =====
// Input front end: item queue that decouples the byte stream from the core.
module rmd_front #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rmd_pkg::t_in_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output rmd_pkg::t_in_item o_item
);
    import rmd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_in_item        r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_push, w_pop;

    // Items that change nothing are dropped here.
    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign w_push  = i_valid && o_ready && (i_item.byte_present || i_item.end_of_message);
    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_pop) else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + (AW+1)'(1)))
        else $error("count did not follow push");
endmodule

// ===== hdl/rmd_core.sv =====
// Back end: block assembly, padding, round engine and digest output.
module rmd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rmd_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output rmd_pkg::t_out_item o_item
);
    import rmd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_ROUND, S_FINAL, S_OUT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_blk [16];
    logic [63:0]  r_len;
    logic [5:0]   r_pos;
    logic [6:0]   r_rnd;
    logic [31:0]  r_ch [5];
    logic [31:0]  r_l [5];
    logic [31:0]  r_r [5];
    logic         r_pad_mode;   // 0x80 marker still to be written
    logic         r_padding;    // end item seen, padding in progress
    logic         r_last_blk;   // block under compression is the final one
    logic [2:0]   r_wn;
    logic         r_ovalid;
    logic [31:0]  r_oword;

    logic [2:0]   w_g, w_gr;
    logic [31:0]  w_tl, w_tr;
    logic [3:0]   w_wi;
    logic [4:0]   w_sh;

    assign w_g  = 3'(r_rnd[6:4]);
    assign w_gr = 3'd4 - w_g;
    assign w_tl = rotl(r_l[0] + bool_fn(w_g, r_l[1], r_l[2], r_l[3]) + r_blk[SEL_L[r_rnd]]
                       + k_left(w_g), ROT_L[r_rnd]) + r_l[4];
    assign w_tr = rotl(r_r[0] + bool_fn(w_gr, r_r[1], r_r[2], r_r[3]) + r_blk[SEL_R[r_rnd]]
                       + k_right(w_g), ROT_R[r_rnd]) + r_r[4];
    assign w_wi = r_pos[5:2];
    assign w_sh = {r_pos[1:0], 3'b000};

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = '{digest_word: r_oword, word_number: r_wn, last_word: (r_wn == 3'd4)};

    function automatic logic [31:0] put(input logic [31:0] w, input logic [4:0] sh,
                                        input logic [7:0] b);
        put = (w & ~(32'hff << sh)) | (32'(b) << sh);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_pos      <= '0;
            r_rnd      <= '0;
            r_ch       <= '{H0, H1, H2, H3, H4};
            r_pad_mode <= 1'b0;
            r_padding  <= 1'b0;
            r_last_blk <= 1'b0;
            r_wn       <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_item.byte_present) begin
                            r_blk[w_wi] <= put(r_blk[w_wi], w_sh, i_item.msg_byte);
                            r_len       <= r_len + 64'd8;
                            r_pos       <= r_pos + 6'd1;
                        end
                        r_pad_mode <= i_item.end_of_message;
                        r_padding  <= i_item.end_of_message;
                        r_last_blk <= 1'b0;
                        if (i_item.byte_present && r_pos == 6'd63) begin
                            r_state <= S_ROUND;
                            r_rnd   <= '0;
                            r_l     <= r_ch;
                            r_r     <= r_ch;
                        end else if (i_item.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // one byte a cycle: 0x80 first, then zeros
                    r_blk[w_wi] <= put(r_blk[w_wi], w_sh, r_pad_mode ? 8'h80 : 8'h00);
                    r_pad_mode  <= 1'b0;
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_state <= S_ROUND;
                        r_rnd   <= '0;
                        r_l     <= r_ch;
                        r_r     <= r_ch;
                    end else if (r_pos == 6'd55) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_blk[14]  <= r_len[31:0];
                    r_blk[15]  <= r_len[63:32];
                    r_last_blk <= 1'b1;
                    r_state    <= S_ROUND;
                    r_rnd      <= '0;
                    r_l        <= r_ch;
                    r_r        <= r_ch;
                end
                S_ROUND: begin
                    r_l <= '{r_l[4], w_tl, r_l[1], rotl(r_l[2], 5'd10), r_l[3]};
                    r_r <= '{r_r[4], w_tr, r_r[1], rotl(r_r[2], 5'd10), r_r[3]};
                    if (r_rnd == 7'(ROUNDS - 1)) begin
                        r_state <= S_FINAL;
                        r_rnd   <= '0;
                    end else begin
                        r_rnd <= r_rnd + 7'd1;
                    end
                end
                S_FINAL: begin
                    r_ch[0] <= r_ch[1] + r_l[2] + r_r[3];
                    r_ch[1] <= r_ch[2] + r_l[3] + r_r[4];
                    r_ch[2] <= r_ch[3] + r_l[4] + r_r[0];
                    r_ch[3] <= r_ch[4] + r_l[0] + r_r[1];
                    r_ch[4] <= r_ch[0] + r_l[1] + r_r[2];
                    if (r_last_blk) begin
                        r_state <= S_OUT;
                        r_wn    <= '0;
                        r_oword <= r_ch[1] + r_l[2] + r_r[3];
                        r_ovalid <= 1'b1;
                    end else if (r_padding) begin
                        // padding wrapped into a second block, or end flag on a full block
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_wn == 3'd4) begin
                            r_ovalid  <= 1'b0;
                            r_state   <= S_IDLE;
                            r_ch      <= '{H0, H1, H2, H3, H4};
                            r_len     <= '0;
                            r_pos     <= '0;
                            r_padding <= 1'b0;
                        end else begin
                            r_wn    <= r_wn + 3'd1;
                            r_oword <= r_ch[r_wn + 3'd1];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd < 7'(ROUNDS)) else $error("round index out of range");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == S_OUT)) else $error("output valid outside output state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> $stable(r_oword) && $stable(r_wn))
        else $error("digest word changed while stalled");
endmodule

// ===== hdl/ripemd160_hash_unit.sv =====
// Top level of the RIPEMD-160 hash unit: input queue and compression core.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  input   | in        | i_valid / o_ready    | i_item  (byte, present, end)
//  output  | out       | o_valid / i_ready    | o_item  (word, number, last)
//
// Bytes are queued and absorbed one per cycle while the core is idle; a
// full block then runs through the round engine and the chain update,
// and the core takes no new byte until both are done. An end item pads
// one byte per cycle through byte 55 (through byte 63 and a second block
// if needed), writes the length words, runs the final block, then emits
// five digest words, one per accepted cycle. Reset is synchronous, active
// low; it restores the initial chain value. An output stall holds the
// core; the input queue keeps taking items until it is full.
module ripemd160_hash_unit #(
    parameter int unsigned QUEUE_DEPTH = rmd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rmd_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output rmd_pkg::t_out_item o_item
);
    import rmd_pkg::*;

    logic     w_q_valid, w_q_ready;
    t_in_item w_q_item;

    // Front: queue of items waiting for the core
    rmd_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // Back: block buffer, padding and the two round lines
    rmd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );
endmodule
